/* src/pcmrm_pkg.sv */
`default_nettype none

package pcmrm_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH = 4096;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int LVL_W      = 13;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LVL_W-1:0] level_t;

  // Commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_REQ   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_OUTRATE = 2'd2;

  // Formats
  localparam logic [2:0] FMT_WAV8_MONO    = 3'd0;
  localparam logic [2:0] FMT_WAV8_STEREO  = 3'd1;
  localparam logic [2:0] FMT_WAV16_MONO   = 3'd2;
  localparam logic [2:0] FMT_WAV16_STEREO = 3'd3;

  localparam logic [15:0] OUT_RATE_RST = 16'd44100;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        byte_in;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               produced;
    logic               push_dropped;
    level_t             fifo_level;
  } out_item_t;

  // Input rate table, unused codes fall back to 48 kHz
  function automatic logic [15:0] rate_of(logic [3:0] code);
    logic [15:0] r;
    case (code)
      4'd1:    r = 16'd44100;
      4'd2:    r = 16'd32000;
      4'd3:    r = 16'd22050;
      4'd4:    r = 16'd19200;
      4'd5:    r = 16'd16000;
      4'd6:    r = 16'd11025;
      4'd7:    r = 16'd9600;
      4'd8:    r = 16'd8000;
      4'd9:    r = 16'd5513;
      4'd10:   r = 16'd24000;
      4'd11:   r = 16'd12000;
      default: r = 16'd48000;
    endcase
    return r;
  endfunction

  // Bytes per time step
  function automatic logic [2:0] step_bytes(logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_WAV8_STEREO:  n = 3'd2;
      FMT_WAV16_MONO:   n = 3'd2;
      FMT_WAV16_STEREO: n = 3'd4;
      default:          n = 3'd1;
    endcase
    return n;
  endfunction

  // Circular index advance with wrap at the FIFO depth
  function automatic idx_t idx_add(idx_t a, logic [2:0] k);
    logic [IDX_W:0] s;
    s = (IDX_W + 1)'(a) + (IDX_W + 1)'(k);
    if (s >= (IDX_W + 1)'(FIFO_DEPTH)) begin
      s = s - (IDX_W + 1)'(FIFO_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/pcmrm_ram.sv */
`default_nettype none

module pcmrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/pcm_resample_mixer_unit.sv */
// Push, flush and idle commands: the beat passes through S_DONE into the output register.
// Sample request: S_WALK walks time steps at one per cycle; if the FIFO runs short it goes
// to S_DONE, else S_READ reads the step's bps bytes (1 to 4) one a cycle from the FIFO RAM's
// read port, then S_CAP, S_CALC and S_DONE. One item is in work at a time.
// Reset (rst_n low, synchronous): FIFO empty, indexes zero, accumulator one, registers at
// their defaults, no result pending. FIFO RAM contents are not cleared.
`default_nettype none

module pcm_resample_mixer_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pcmrm_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pcmrm_pkg::out_item_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic signed [16:0] MIX_MAX = 17'sd32767;
  localparam logic signed [16:0] MIX_MIN = -17'sd32767;

  // control registers
  logic [2:0]            state_r, state_nxt;
  logic [2:0]            fmt_r, fmt_nxt;
  logic [3:0]            rcode_r, rcode_nxt;
  logic [15:0]           orate_r, orate_nxt;
  pcmrm_pkg::idx_t       rd_r, rd_nxt;
  pcmrm_pkg::idx_t       wr_r, wr_nxt;
  pcmrm_pkg::cnt_t       fill_r, fill_nxt;
  logic signed [17:0]    acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  pend_r, pend_nxt;

  // payload registers
  logic signed [15:0]    mixl_r, mixl_nxt;
  logic signed [15:0]    mixr_r, mixr_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [1:0]            slot_r, slot_nxt;
  logic [7:0]            b_r [4];
  logic [7:0]            b_nxt [4];
  pcmrm_pkg::out_item_t  res_r, res_nxt;
  pcmrm_pkg::out_item_t  out_data_r, out_data_nxt;

  // RAM port
  logic                  ram_we;
  pcmrm_pkg::idx_t       ram_raddr;
  logic [7:0]            ram_q;

  logic                  accept;
  logic [2:0]            bps;
  logic [31:0]           dec;
  logic [15:0]           rate;

  // 8-bit value replicated into both bytes
  function automatic logic [15:0] byte_word(logic [7:0] d);
    return {d, d};
  endfunction

  // decode one step into {left, right}
  function automatic logic [31:0] decode(logic [2:0] fmt, logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3);
    logic [7:0]  d;
    logic [31:0] lr;
    case (fmt)
      pcmrm_pkg::FMT_WAV8_MONO: begin
        d  = b0 - 8'h80;
        lr = {byte_word(d), byte_word(d)};
      end
      pcmrm_pkg::FMT_WAV8_STEREO: begin
        lr = {byte_word(b0 - 8'h80), byte_word(b1 - 8'h80)};
      end
      pcmrm_pkg::FMT_WAV16_MONO: begin
        lr = {b1, b0, b1, b0};
      end
      pcmrm_pkg::FMT_WAV16_STEREO: begin
        lr = {b1, b0, b3, b2};
      end
      default: begin
        // sign-magnitude byte
        d  = b0[7] ? (8'h00 - {1'b0, b0[6:0]}) : b0;
        lr = {byte_word(d), byte_word(d)};
      end
    endcase
    return lr;
  endfunction

  // saturating mix to +/-32767
  function automatic logic signed [15:0] mix_sat(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    logic signed [16:0] s;
    logic signed [16:0] c;
    s = 17'(a) + 17'(b);
    if (s < MIX_MIN) begin
      c = MIX_MIN;
    end else if (s > MIX_MAX) begin
      c = MIX_MAX;
    end else begin
      c = s;
    end
    return c[15:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign bps       = pcmrm_pkg::step_bytes(fmt_r);
  assign rate      = pcmrm_pkg::rate_of(rcode_r);
  assign dec       = decode(fmt_r, b_r[0], b_r[1], b_r[2], b_r[3]);
  assign ram_we    = accept && (in_data.cmd == pcmrm_pkg::CMD_PUSH) &&
                     (fill_r < pcmrm_pkg::cnt_t'(pcmrm_pkg::FIFO_DEPTH));
  assign ram_raddr = pcmrm_pkg::idx_add(rd_r, {1'b0, k_r});
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pcmrm_ram #(
    .WIDTH (8),
    .DEPTH (pcmrm_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (in_data.byte_in),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    rcode_nxt     = rcode_r;
    orate_nxt     = orate_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    fill_nxt      = fill_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mixl_nxt      = mixl_r;
    mixr_nxt      = mixr_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    b_nxt         = b_r;
    pend_nxt      = (state_r == S_READ);
    slot_nxt      = k_r;

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        pcmrm_pkg::REG_FORMAT:  fmt_nxt   = cfg_wdata[2:0];
        pcmrm_pkg::REG_RATE:    rcode_nxt = cfg_wdata[3:0];
        pcmrm_pkg::REG_OUTRATE: orate_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // capture RAM read data in the cycle after the address
    if (pend_r) begin
      b_nxt[slot_r] = ram_q;
    end

    // output register drains
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mixl_nxt             = in_data.mix_left;
          mixr_nxt             = in_data.mix_right;
          res_nxt.push_dropped = 1'b0;
          state_nxt            = S_DONE;
          case (in_data.cmd)
            pcmrm_pkg::CMD_PUSH: begin
              if (ram_we) begin
                wr_nxt   = pcmrm_pkg::idx_add(wr_r, 3'd1);
                fill_nxt = fill_r + pcmrm_pkg::cnt_t'(1);
              end else begin
                res_nxt.push_dropped = 1'b1;
              end
            end
            pcmrm_pkg::CMD_REQ: begin
              state_nxt = S_WALK;
            end
            pcmrm_pkg::CMD_FLUSH: begin
              rd_nxt   = '0;
              wr_nxt   = '0;
              fill_nxt = '0;
              acc_nxt  = 18'sd1;
            end
            default: ;
          endcase
          res_nxt.out_left   = in_data.mix_left;
          res_nxt.out_right  = in_data.mix_right;
          res_nxt.produced   = 1'b0;
          res_nxt.fifo_level = pcmrm_pkg::level_t'(fill_nxt);
        end
      end

      // one time step per cycle
      S_WALK: begin
        if (fill_r < pcmrm_pkg::cnt_t'(bps)) begin
          res_nxt.out_left     = mixl_r;
          res_nxt.out_right    = mixr_r;
          res_nxt.produced     = 1'b0;
          res_nxt.push_dropped = 1'b0;
          res_nxt.fifo_level   = pcmrm_pkg::level_t'(fill_r);
          state_nxt            = S_DONE;
        end else if (acc_r > 18'sd0) begin
          k_nxt     = 2'd0;
          state_nxt = S_READ;
        end else begin
          acc_nxt  = acc_r + $signed({2'b00, orate_r});
          rd_nxt   = pcmrm_pkg::idx_add(rd_r, bps);
          fill_nxt = fill_r - pcmrm_pkg::cnt_t'(bps);
        end
      end

      // fetch the step's bytes, one address per cycle
      S_READ: begin
        k_nxt = k_r + 2'd1;
        if ({1'b0, k_r} == (bps - 3'd1)) begin
          state_nxt = S_CAP;
        end
      end

      S_CAP: begin
        state_nxt = S_CALC;
      end

      // decode, mix and saturate; the step stays in the FIFO
      S_CALC: begin
        res_nxt.out_left     = mix_sat(mixl_r, dec[31:16]);
        res_nxt.out_right    = mix_sat(mixr_r, dec[15:0]);
        res_nxt.produced     = 1'b1;
        res_nxt.push_dropped = 1'b0;
        res_nxt.fifo_level   = pcmrm_pkg::level_t'(fill_r);
        acc_nxt              = acc_r - $signed({2'b00, rate});
        state_nxt            = S_DONE;
      end

      // hand the result to the output register when it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fmt_r       <= '0;
      rcode_r     <= '0;
      orate_r     <= pcmrm_pkg::OUT_RATE_RST;
      rd_r        <= '0;
      wr_r        <= '0;
      fill_r      <= '0;
      acc_r       <= 18'sd1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      rcode_r     <= rcode_nxt;
      orate_r     <= orate_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      fill_r      <= fill_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mixl_r     <= mixl_nxt;
    mixr_r     <= mixr_nxt;
    k_r        <= k_nxt;
    slot_r     <= slot_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* src/pcmrm_checker.sv */
`default_nettype none

module pcmrm_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire pcmrm_pkg::out_item_t out_data
);

  // one item in work: ready drops right after an input beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in work");

  // a new result appears only as the block returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while still busy");

  // a dropped push and a produced sample never share one result
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.produced && out_data.push_dropped))
    else $error("produced and push_dropped both set");

  // dropped pushes only happen on a full FIFO
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.push_dropped) |->
      (out_data.fifo_level == pcmrm_pkg::level_t'(pcmrm_pkg::FIFO_DEPTH)))
    else $error("push dropped while FIFO not full");

endmodule

bind pcm_resample_mixer_unit pcmrm_checker u_pcmrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
